>>> rtl/serial_display_frame_parser_defines.svh
// Assertion macros for the checks in the frame parser top module.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef SERIAL_DISPLAY_FRAME_PARSER_DEFINES_SVH
`define SERIAL_DISPLAY_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDFP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sdfp_pkg.sv
`timescale 1ns / 1ps
package sdfp_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
	localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_LEN,
		PH_CMD,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_LOAD
	} back_state_t;

	// One finished frame, or one oversized length report.
	typedef struct packed {
		logic       err;
		logic [7:0] cmd;
		logic [7:0] len;
		logic [6:0] cnt;
		logic       bank;
	} desc_t;

	// Buffer release from the back part to the front part.
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

>>> rtl/serial_display_frame_parser.sv
`timescale 1ns / 1ps
// Frame parser for a serial display link. Received bytes enter on the slave
// stream, one per cycle when the parser is ready; it hunts for the two header
// bytes, then takes a length byte, a command byte and the payload into one of
// two payload buffers. A completed frame is queued and drained as one result
// per payload byte on the master stream, with the final one marked by tlast.
// Each payload result passes a read state and then a load state, set by the
// registered read of the payload buffer; an oversized length gives a
// single error result. The input side stalls only while a new payload
// would land in a buffer still being drained, or while the two-entry frame
// queue is full. The header bytes are set through the configuration port.
`include "serial_display_frame_parser_defines.svh"
module serial_display_frame_parser import sdfp_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // rx_byte
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// command, payload_length, byte_index, payload_byte, two zero bits
	output logic [31:0]          m_axis_tdata,
	output logic                 m_axis_tlast,
	output logic                 m_axis_tuser,  // length_error
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam int IDX_W  = $clog2((MAX_PAYLOAD > 1) ? MAX_PAYLOAD : 2);
	localparam int ADDR_W = IDX_W + 1;

	logic [7:0] header_first_q;
	logic [7:0] header_second_q;

	logic              q_push;
	desc_t             q_push_desc;
	logic              q_full;
	logic              q_pop;
	desc_t             q_pop_desc;
	logic              q_empty;
	rel_t              rel;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	logic [7:0] out_command;
	logic [7:0] out_length;
	logic [5:0] out_index;
	logic [7:0] out_byte;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {2'b00, out_byte, out_index, out_length, out_command};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEADER_FIRST:  header_first_q  <= cfg_data;
				REG_HEADER_SECOND: header_second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sdfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_byte      (s_axis_tdata),
		.header_first (header_first_q),
		.header_second(header_second_q),
		.q_full       (q_full),
		.push         (q_push),
		.push_desc    (q_push_desc),
		.rel          (rel),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

	sdfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_desc(q_push_desc),
		.full     (q_full),
		.pop      (q_pop),
		.pop_desc (q_pop_desc),
		.empty    (q_empty)
	);

	sdfp_ram #(
		.WIDTH(8),
		.DEPTH(2 ** ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sdfp_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_desc     (q_pop_desc),
		.q_pop      (q_pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.rel        (rel),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_command(out_command),
		.out_length (out_length),
		.out_index  (out_index),
		.out_byte   (out_byte),
		.out_last   (m_axis_tlast),
		.out_error  (m_axis_tuser)
	);

	`SDFP_ASSERT_SAME(a_err_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error item without tlast")
	`SDFP_ASSERT_SAME(a_no_push_full, q_push, !q_full || q_pop, "frame queue overflow")
	`SDFP_ASSERT_SAME(a_bank_apart, ram_we && ram_re, ram_waddr[ADDR_W-1] != ram_raddr[ADDR_W-1], "payload write hit the buffer being drained")

endmodule

>>> rtl/sdfp_ram.sv
`timescale 1ns / 1ps
module sdfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/sdfp_queue.sv
`timescale 1ns / 1ps
module sdfp_queue import sdfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output desc_t pop_desc,
	output logic  empty
);

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/sdfp_front.sv
`timescale 1ns / 1ps
module sdfp_front import sdfp_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int IDX_W = $clog2((MAX_PAYLOAD > 1) ? MAX_PAYLOAD : 2),
	localparam int ADDR_W = IDX_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        header_first,
	input  logic [7:0]        header_second,
	input  logic              q_full,
	output logic              push,
	output desc_t             push_desc,
	input  rel_t              rel,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [7:0]        ram_wdata
);

	phase_t     phase_q, phase_d;
	logic [6:0] count_q;
	logic [7:0] len_q;
	logic [7:0] cmd_q;
	logic       wr_bank_q;
	logic [1:0] busy_q, busy_d;

	logic       accept;
	logic       too_long;
	logic [6:0] count_next;
	logic [7:0] need;
	logic       done;

	assign in_ready   = !q_full && !((phase_q == PH_DATA) && busy_q[wr_bank_q]);
	assign accept     = in_valid && in_ready;
	assign too_long   = in_byte > 8'(MAX_PAYLOAD);
	assign count_next = count_q + 7'd1;
	assign need       = (len_q == 8'd0) ? 8'd1 : len_q;
	assign done       = ({1'b0, count_next} == need);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT1: begin
				if (accept && (in_byte == header_first)) begin
					phase_d = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				if (accept) begin
					phase_d = (in_byte == header_second) ? PH_LEN : PH_HUNT1;
				end
			end
			PH_LEN: begin
				if (accept) begin
					phase_d = too_long ? PH_HUNT1 : PH_CMD;
				end
			end
			PH_CMD: begin
				if (accept) begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (accept && done) begin
					phase_d = PH_HUNT1;
				end
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	always_comb begin
		push      = 1'b0;
		push_desc = '0;
		ram_we    = 1'b0;
		ram_waddr = {wr_bank_q, count_q[IDX_W-1:0]};
		ram_wdata = in_byte;
		case (phase_q)
			PH_LEN: begin
				if (accept && too_long) begin
					push          = 1'b1;
					push_desc.err = 1'b1;
					push_desc.len = in_byte;
				end
			end
			PH_DATA: begin
				if (accept) begin
					ram_we = 1'b1;
					if (done) begin
						push           = 1'b1;
						push_desc.cmd  = cmd_q;
						push_desc.len  = len_q;
						push_desc.cnt  = count_next;
						push_desc.bank = wr_bank_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (push && !push_desc.err) begin
			busy_d[wr_bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT1;
			count_q   <= 7'd0;
			len_q     <= 8'd0;
			cmd_q     <= 8'd0;
			wr_bank_q <= 1'b0;
			busy_q    <= 2'b00;
		end else begin
			phase_q <= phase_d;
			busy_q  <= busy_d;
			if (accept) begin
				case (phase_q)
					PH_HUNT2: begin
						count_q <= 7'd0;
					end
					PH_LEN: begin
						if (!too_long) begin
							len_q <= in_byte;
						end
					end
					PH_CMD: begin
						cmd_q   <= in_byte;
						count_q <= 7'd0;
					end
					PH_DATA: begin
						count_q <= done ? 7'd0 : count_next;
						if (done) begin
							wr_bank_q <= ~wr_bank_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/sdfp_back.sv
`timescale 1ns / 1ps
module sdfp_back import sdfp_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int IDX_W = $clog2((MAX_PAYLOAD > 1) ? MAX_PAYLOAD : 2),
	localparam int ADDR_W = IDX_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  desc_t             q_desc,
	output logic              q_pop,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [7:0]        ram_rdata,
	output rel_t              rel,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_command,
	output logic [7:0]        out_length,
	output logic [5:0]        out_index,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic              out_error
);

	back_state_t state_q, state_d;
	desc_t       cur_q;
	logic [6:0]  idx_q;
	logic        out_valid_q;

	logic out_free;
	logic is_last;
	logic load_err;
	logic load_data;

	assign out_free  = !out_valid_q || out_ready;
	assign is_last   = ((idx_q + 7'd1) == cur_q.cnt);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && !q_desc.err) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				state_d = BK_LOAD;
			end
			BK_LOAD: begin
				if (out_free) begin
					state_d = is_last ? BK_IDLE : BK_READ;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		load_err  = 1'b0;
		load_data = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = {cur_q.bank, idx_q[IDX_W-1:0]};
		case (state_q)
			BK_IDLE: begin
				q_pop    = !q_empty && (!q_desc.err || out_free);
				load_err = !q_empty && q_desc.err && out_free;
			end
			BK_READ: begin
				ram_re = 1'b1;
			end
			BK_LOAD: begin
				load_data = out_free;
			end
			default: begin
			end
		endcase
		rel.valid = load_data && is_last;
		rel.bank  = cur_q.bank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cur_q       <= '0;
			idx_q       <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cur_q <= q_desc;
				idx_q <= 7'd0;
			end else if (load_data) begin
				idx_q <= idx_q + 7'd1;
			end
			if (load_err || load_data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_err) begin
			out_command <= 8'd0;
			out_length  <= q_desc.len;
			out_index   <= 6'd0;
			out_byte    <= 8'd0;
			out_last    <= 1'b1;
			out_error   <= 1'b1;
		end else if (load_data) begin
			out_command <= cur_q.cmd;
			out_length  <= cur_q.len;
			out_index   <= idx_q[5:0];
			out_byte    <= ram_rdata;
			out_last    <= is_last;
			out_error   <= 1'b0;
		end
	end

endmodule

>>> tb/frame_result_checker.sv
`timescale 1ns / 1ps
module frame_result_checker import sdfp_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [31:0]          m_axis_tdata,
	input  logic                 m_axis_tlast,
	input  logic                 m_axis_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   mismatch_count,
	output int                   pending_results
);

	typedef struct packed {
		logic [7:0] cmd;
		logic [7:0] len;
		logic [5:0] idx;
		logic [7:0] data;
		logic       last;
		logic       err;
	} frame_result_t;

	frame_result_t expected_results[$];
	int            errors;
	logic [7:0]    hdr_first;
	logic [7:0]    hdr_second;
	phase_t        parse_phase;
	logic [6:0]    stored_count;
	logic [7:0]    frame_len;
	logic [7:0]    frame_cmd;
	logic [7:0]    payload_mem [MAX_PAYLOAD];

	task automatic clear_frame();
		stored_count = '0;
		frame_len = '0;
		frame_cmd = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		frame_result_t r;
		int need;
		case (parse_phase)
			PH_HUNT1: begin
				if (b == hdr_first) begin
					parse_phase = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				// A wrong second byte is not tried again as a first byte.
				if (b == hdr_second) begin
					parse_phase = PH_LEN;
				end else begin
					parse_phase = PH_HUNT1;
				end
				stored_count = '0;
			end
			PH_LEN: begin
				if (b > MAX_PAYLOAD) begin
					r = '0;
					r.len = b;
					r.last = 1'b1;
					r.err = 1'b1;
					expected_results.push_back(r);
					clear_frame();
					parse_phase = PH_HUNT1;
				end else begin
					frame_len = b;
					parse_phase = PH_CMD;
				end
			end
			PH_CMD: begin
				frame_cmd = b;
				stored_count = '0;
				parse_phase = PH_DATA;
			end
			PH_DATA: begin
				if (stored_count < MAX_PAYLOAD) begin
					payload_mem[stored_count] = b;
				end
				stored_count++;
				// A zero length still takes one payload byte.
				need = (frame_len == 0) ? 1 : frame_len;
				if (stored_count >= need) begin
					for (int i = 0; i < stored_count && i < MAX_PAYLOAD; i++) begin
						r.cmd = frame_cmd;
						r.len = frame_len;
						r.idx = i[5:0];
						r.data = payload_mem[i];
						r.last = (i + 1 == stored_count);
						r.err = 1'b0;
						expected_results.push_back(r);
					end
					clear_frame();
					parse_phase = PH_HUNT1;
				end
			end
			default: begin
				clear_frame();
				parse_phase = PH_HUNT1;
			end
		endcase
	endtask

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		frame_result_t want;
		frame_result_t got;
		got.cmd = m_axis_tdata[7:0];
		got.len = m_axis_tdata[15:8];
		got.idx = m_axis_tdata[21:16];
		got.data = m_axis_tdata[29:22];
		got.last = m_axis_tlast;
		got.err = m_axis_tuser;
		if (expected_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, got tdata=%h tlast=%b tuser=%b",
				$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
			return;
		end
		want = expected_results.pop_front();
		compare_field("command", want.cmd, got.cmd);
		compare_field("payload_length", want.len, got.len);
		compare_field("byte_index", want.idx, got.idx);
		compare_field("payload_byte", want.data, got.data);
		compare_field("last", want.last, got.last);
		compare_field("length_error", want.err, got.err);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			errors = 0;
			hdr_first = HEADER_FIRST_RST;
			hdr_second = HEADER_SECOND_RST;
			parse_phase = PH_HUNT1;
			clear_frame();
			mismatch_count <= 0;
			pending_results <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_HEADER_FIRST) begin
					hdr_first = cfg_data;
				end else if (cfg_index == REG_HEADER_SECOND) begin
					hdr_second = cfg_data;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tdata);
			end
			mismatch_count <= errors;
			pending_results <= expected_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import sdfp_pkg::*;

	localparam int RESET_CYCLES    = 8;
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [31:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	int         mismatch_count;
	int         pending_results;
	int         items_sent = 0;
	int         idle_cycles = 0;
	int         tx_idle_pct = 19;
	int         rx_idle_pct = 61;
	logic       hold_off_req = 1'b0;
	logic [7:0] hdr_first;
	logic [7:0] hdr_second;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	serial_display_frame_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	frame_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.m_axis_tuser    (m_axis_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_header();
		send_byte(hdr_first);
		send_byte(hdr_second);
	endtask

	task automatic send_frame_body(input logic [7:0] len);
		send_byte(len);
		if (len > MAX_PAYLOAD_DEF) begin
			return;
		end
		send_byte(8'($urandom_range(255)));
		repeat ((len == 0) ? 1 : len) send_byte(8'($urandom_range(255)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_HEADER_FIRST) begin
			hdr_first = value;
		end else if (idx == REG_HEADER_SECOND) begin
			hdr_second = value;
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly complete frames with small lengths; the rest is oversized lengths,
	// broken headers and line noise.
	task automatic random_traffic(input int budget);
		int first_item;
		int pick;
		int len;
		first_item = items_sent;
		while (items_sent - first_item < budget) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = $urandom_range(99);
				if (len < 6) begin
					len = MAX_PAYLOAD_DEF;
				end else if (len < 16) begin
					len = $urandom_range(MAX_PAYLOAD_DEF - 1, 9);
				end else begin
					len = $urandom_range(8);
				end
				send_header();
				send_frame_body(len[7:0]);
			end else if (pick < 80) begin
				send_header();
				send_byte(8'($urandom_range(255, MAX_PAYLOAD_DEF + 1)));
			end else if (pick < 90) begin
				send_byte(hdr_first);
				send_byte(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_HEADER_FIRST;
		cfg_data = '0;
		hdr_first = HEADER_FIRST_RST;
		hdr_second = HEADER_SECOND_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_header();
		send_byte(8'd0);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_header();
		send_byte(8'd1);
		send_byte(8'h00);
		send_byte(8'h00);
		send_header();
		send_byte(8'd2);
		send_byte(8'h3C);
		send_byte(8'h55);
		send_byte(8'hAA);
		// The repeated first byte fails as a second byte and is then dropped.
		send_byte(hdr_first);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_header();
		send_byte(8'(MAX_PAYLOAD_DEF + 1));
		send_header();
		send_byte(8'hFF);
		random_traffic(35);
		wait_drained();

		tx_idle_pct = 61;
		rx_idle_pct = 19;
		write_reg(REG_HEADER_FIRST, 8'h00);
		write_reg(REG_HEADER_SECOND, 8'hFF);
		write_reg(REG_UNUSED, 8'h5A);
		cfg_valid <= 1'b0;
		hold_off_req = 1'b1;
		repeat (4) begin
			send_header();
			send_frame_body(8'd6);
		end
		wait_drained();
		random_traffic(30);

		// Change the headers while the parser waits for the second header byte.
		send_byte(hdr_first);
		wait_drained();
		write_reg(REG_HEADER_FIRST, 8'hFF);
		write_reg(REG_HEADER_SECOND, 8'h00);
		cfg_valid <= 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_byte(hdr_second);
		send_frame_body(8'd3);
		random_traffic(25);
		wait_drained();

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/sdfp_pkg.sv
rtl/sdfp_ram.sv
rtl/sdfp_queue.sv
rtl/sdfp_front.sv
rtl/sdfp_back.sv
rtl/serial_display_frame_parser.sv
tb/frame_result_checker.sv
tb/tb_top.sv
